>>> sv/tgd_pkg.sv
// ----------------------------------------------------------------------------
// tgd_pkg: shared types and constants for the touch gesture detector
// Holds gesture-machine codes, event codes, register indexes and the
// state and configuration structs passed between modules.
// ----------------------------------------------------------------------------
package tgd_pkg;

    localparam int unsigned READING_W = 16;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned GSTATE_W  = 3;
    localparam int unsigned EVENT_W   = 2;

    // input tdata: touch_reading, time_ms, force_idle, zero fill
    localparam int unsigned IN_DATA_W  = 56;
    // output tdata: gesture, touched_level, zero fill
    localparam int unsigned OUT_DATA_W = 8;

    // gesture machine states
    localparam logic [GSTATE_W-1:0] GS_IDLE     = 3'd0;
    localparam logic [GSTATE_W-1:0] GS_PRESSED  = 3'd1;
    localparam logic [GSTATE_W-1:0] GS_HELD     = 3'd2;
    localparam logic [GSTATE_W-1:0] GS_TAP_WAIT = 3'd3;
    localparam logic [GSTATE_W-1:0] GS_SECOND   = 3'd4;

    // reported events
    localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
    localparam logic [EVENT_W-1:0] EV_TAP    = 2'd1;
    localparam logic [EVENT_W-1:0] EV_DOUBLE = 2'd2;
    localparam logic [EVENT_W-1:0] EV_HOLD   = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD       = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_GAP = 8'd3;

    // register reset values
    localparam logic [CFG_W-1:0] THRESHOLD_RST  = 16'd95;
    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd20;
    localparam logic [CFG_W-1:0] HOLD_RST       = 16'd1000;
    localparam logic [CFG_W-1:0] DOUBLE_GAP_RST = 16'd400;

    typedef struct packed {
        logic [CFG_W-1:0] touch_cutoff;
        logic [CFG_W-1:0] debounce_time;
        logic [CFG_W-1:0] hold_time;
        logic [CFG_W-1:0] double_tap_gap;
    } tgd_cfg_t;

    typedef struct packed {
        logic                last_raw_level;
        logic [TIME_W-1:0]   debounce_start;
        logic                stable_level;
        logic [GSTATE_W-1:0] gesture_state;
        logic [TIME_W-1:0]   press_start;
        logic [TIME_W-1:0]   release_time;
    } tgd_state_t;

    typedef struct packed {
        logic [READING_W-1:0] touch_reading;
        logic [TIME_W-1:0]    time_ms;
        logic                 force_idle;
    } tgd_sample_t;

    typedef struct packed {
        logic [EVENT_W-1:0] gesture;
        logic               touched_level;
    } tgd_result_t;

endpackage

>>> sv/tgd_cfg_regs.sv
// ----------------------------------------------------------------------------
// tgd_cfg_regs: configuration register file
// Four 16-bit registers written through a valid/ready channel; writes to
// indexes beyond the list are dropped.
// ----------------------------------------------------------------------------
module tgd_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [tgd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tgd_pkg::CFG_W-1:0]    cfg_data,
    output tgd_pkg::tgd_cfg_t            cfg
);
    import tgd_pkg::*;

    tgd_cfg_t cfg_reg;
    tgd_cfg_t cfg_next;
    logic     wr_en;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid & cfg_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (cfg_index)
                REG_THRESHOLD:  cfg_next.touch_cutoff   = cfg_data;
                REG_DEBOUNCE:   cfg_next.debounce_time  = cfg_data;
                REG_HOLD:       cfg_next.hold_time      = cfg_data;
                REG_DOUBLE_GAP: cfg_next.double_tap_gap = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.touch_cutoff   <= THRESHOLD_RST;
            cfg_reg.debounce_time  <= DEBOUNCE_RST;
            cfg_reg.hold_time      <= HOLD_RST;
            cfg_reg.double_tap_gap <= DOUBLE_GAP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/tgd_step.sv
// ----------------------------------------------------------------------------
// tgd_step: per-sample debounce and gesture update
// Combinational next-state and result for one sample given current state.
// ----------------------------------------------------------------------------
module tgd_step (
    input  tgd_pkg::tgd_cfg_t    cfg,
    input  tgd_pkg::tgd_state_t  state,
    input  tgd_pkg::tgd_sample_t sample,
    output tgd_pkg::tgd_state_t  state_next,
    output tgd_pkg::tgd_result_t result
);
    import tgd_pkg::*;

    logic              raw;
    logic [TIME_W-1:0] db_start;
    logic [TIME_W-1:0] db_diff;
    logic [TIME_W-1:0] press_diff;
    logic [TIME_W-1:0] gap_diff;
    logic              db_done;
    logic              hold_done;
    logic              gap_done;
    logic              level;
    logic [EVENT_W-1:0] ev;

    assign raw        = sample.touch_reading < cfg.touch_cutoff;
    // restart the window on any raw level change
    assign db_start   = (raw != state.last_raw_level) ? sample.time_ms : state.debounce_start;
    assign db_diff    = sample.time_ms - db_start;
    assign press_diff = sample.time_ms - state.press_start;
    assign gap_diff   = sample.time_ms - state.release_time;
    assign db_done    = db_diff >= TIME_W'(cfg.debounce_time);
    assign hold_done  = press_diff >= TIME_W'(cfg.hold_time);
    assign gap_done   = gap_diff >= TIME_W'(cfg.double_tap_gap);
    assign level      = db_done ? raw : state.stable_level;

    always_comb
    begin
        state_next                = state;
        state_next.last_raw_level = raw;
        state_next.debounce_start = db_start;
        state_next.stable_level   = level;
        ev                        = EV_NONE;

        case (state.gesture_state)
            GS_PRESSED:
            begin
                if (!level)
                begin
                    state_next.gesture_state = GS_TAP_WAIT;
                    state_next.release_time  = sample.time_ms;
                end
                else if (hold_done)
                begin
                    state_next.gesture_state = GS_HELD;
                end
            end
            GS_HELD:
            begin
                if (!level)
                begin
                    state_next.gesture_state = GS_IDLE;
                    ev                       = EV_HOLD;
                end
            end
            GS_TAP_WAIT:
            begin
                if (level)
                begin
                    state_next.gesture_state = GS_SECOND;
                    state_next.press_start   = sample.time_ms;
                end
                else if (gap_done)
                begin
                    state_next.gesture_state = GS_IDLE;
                    ev                       = EV_TAP;
                end
            end
            GS_SECOND:
            begin
                if (!level)
                begin
                    state_next.gesture_state = GS_IDLE;
                    ev                       = EV_DOUBLE;
                end
                else if (hold_done)
                begin
                    state_next.gesture_state = GS_HELD;
                end
            end
            default:
            begin
                // idle, and unused codes behave as idle
                state_next.gesture_state = GS_IDLE;
                if (level)
                begin
                    state_next.gesture_state = GS_PRESSED;
                    state_next.press_start   = sample.time_ms;
                end
            end
        endcase

        if (sample.force_idle)
        begin
            state_next.gesture_state = GS_IDLE;
        end
    end

    assign result.gesture       = ev;
    assign result.touched_level = level;

endmodule

>>> sv/touch_gesture_detector.sv
// ----------------------------------------------------------------------------
// touch_gesture_detector: tap / double tap / hold detector for a touch pad
// Debounces a thresholded sensor reading and runs a gesture machine on it.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one sensor sample per transfer, carrying the raw
//   reading, a millisecond timestamp and a force-idle flag.
//   Output stream (m_*): one result per sample, carrying the gesture event
//   (none, tap, double tap, hold) and the debounced touched level.
//   Config channel (cfg_*): write register cfg_index with cfg_data; always
//   ready. Write only while no samples are in flight.
// Path: a sample accepted on the input passes two register stages, the
//   sample register and then the result register, before it shows on m_tvalid.
// Throughput: one sample per cycle while the result stream is not stalled;
//   the input register feeds the step logic, which updates the detector state
//   and the result register in the same cycle, so the state loop closes there.
// Reset: rst_n clears both valid flags and the detector state and loads the
//   register reset values (threshold 95, debounce 20, hold 1000, gap 400).
// Stall: when m_tready is low the result holds; one more sample may wait
//   in the sample register, then s_tready drops until the result transfers.
// ----------------------------------------------------------------------------
module touch_gesture_detector (
    input  logic                          clk,
    input  logic                          rst_n,
    // s_tdata: touch_reading[15:0], time_ms[47:16], force_idle[48], zero[55:49]
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tgd_pkg::IN_DATA_W-1:0] s_tdata,
    // m_tdata: gesture[1:0], touched_level[2], zero[7:3]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tgd_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tgd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tgd_pkg::CFG_W-1:0]     cfg_data
);
    import tgd_pkg::*;

    tgd_cfg_t    cfg;
    tgd_sample_t sample_reg;
    tgd_sample_t sample_next;
    logic        in_valid_reg;
    logic        in_valid_next;
    tgd_state_t  state_reg;
    tgd_state_t  state_next;
    tgd_state_t  step_state;
    tgd_result_t step_result;
    tgd_result_t result_reg;
    tgd_result_t result_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;
    logic        process;
    logic        in_xfer;

    tgd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tgd_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .sample     (sample_reg),
        .state_next (step_state),
        .result     (step_result)
    );

    // result slot is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || m_tready;
    // step the held sample whenever the result slot can take it
    assign process  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign in_xfer  = s_tvalid && s_tready;

    always_comb
    begin
        sample_next   = sample_reg;
        in_valid_next = in_valid_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
        end
        if (in_xfer)
        begin
            sample_next.touch_reading = s_tdata[15:0];
            sample_next.time_ms       = s_tdata[47:16];
            sample_next.force_idle    = s_tdata[48];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (process)
        begin
            state_next     = step_state;
            result_next    = step_result;
            out_valid_next = 1'b1;
        end
    end

    // control and detector state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{last_raw_level: 1'b0, debounce_start: '0,
                               stable_level: 1'b0, gesture_state: GS_IDLE,
                               press_start: '0, release_time: '0};
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // payload: no reset needed
    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        result_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, result_reg.touched_level, result_reg.gesture};

endmodule

>>> sv/tgd_checker.sv
// ----------------------------------------------------------------------------
// tgd_checker: port-level checks for the touch gesture detector
// Watches the top-level ports and flags protocol or behavior slips.
// ----------------------------------------------------------------------------
module tgd_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [tgd_pkg::OUT_DATA_W-1:0] m_tdata
);
    import tgd_pkg::*;

    // no result is offered while in reset
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

    // a stalled result holds until transferred
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // input backpressure only comes from a stalled, full result slot
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output stall");

    // every gesture event is reported on an untouched sample
    a_event_released: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] != EV_NONE) |-> !m_tdata[2])
        else $error("gesture event while touched");

endmodule

bind touch_gesture_detector tgd_checker u_tgd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/sv/touch_gesture_detector_tb.sv
// ----------------------------------------------------------------------------
// touch_gesture_detector_tb: self-checking testbench for the gesture detector
// Drives sensor samples into the input stream with bursty gaps and stalls
// the result stream on its own pattern. An in-bench detector predicts each
// result, and every result transfer is compared against the oldest
// prediction. A directed table opens the run. Randomized tap, double tap,
// hold, bounce and noise sequences follow under several register settings,
// the extremes among them.
// ----------------------------------------------------------------------------
module touch_gesture_detector_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tgd_pkg::*;

    // Cycles to let pass after the last result before touching registers;
    // the block has two register stages.
    localparam int unsigned SETTLE_CYCLES = 4;

    logic                   clk       = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data  = '0;

    touch_gesture_detector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Assert reset at time zero as a real edge, release it on a falling edge.
    initial
    begin
        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Detector prediction: own copy of the registers and the state
    // ------------------------------------------------------------------
    tgd_cfg_t    det_cfg   = '{THRESHOLD_RST, DEBOUNCE_RST, HOLD_RST, DOUBLE_GAP_RST};
    tgd_state_t  det_state = '0;
    tgd_result_t pending_results[$];

    int unsigned samples_sent    = 0;
    int unsigned results_checked = 0;
    int unsigned settings_count  = 0;
    int unsigned errors          = 0;

    // Advance the predicted detector by one sample and return its result.
    function automatic tgd_result_t predict_gesture(input tgd_sample_t smp);
        logic              raw;
        logic              level;
        logic [TIME_W-1:0] elapsed;
        tgd_result_t       res;
        raw         = smp.touch_reading < det_cfg.touch_cutoff;
        res.gesture = EV_NONE;
        // Any change of the raw level restarts the debounce window.
        if (raw != det_state.last_raw_level)
        begin
            det_state.last_raw_level = raw;
            det_state.debounce_start = smp.time_ms;
        end
        level   = det_state.stable_level;
        elapsed = smp.time_ms - det_state.debounce_start;
        if (elapsed >= {16'h0, det_cfg.debounce_time})
        begin
            level                  = raw;
            det_state.stable_level = raw;
        end
        case (det_state.gesture_state)
            GS_PRESSED:
            begin
                elapsed = smp.time_ms - det_state.press_start;
                if (!level)
                begin
                    det_state.gesture_state = GS_TAP_WAIT;
                    det_state.release_time  = smp.time_ms;
                end
                else if (elapsed >= {16'h0, det_cfg.hold_time})
                    det_state.gesture_state = GS_HELD;
            end
            GS_HELD:
            begin
                if (!level)
                begin
                    det_state.gesture_state = GS_IDLE;
                    res.gesture             = EV_HOLD;
                end
            end
            GS_TAP_WAIT:
            begin
                elapsed = smp.time_ms - det_state.release_time;
                if (level)
                begin
                    det_state.gesture_state = GS_SECOND;
                    det_state.press_start   = smp.time_ms;
                end
                else if (elapsed >= {16'h0, det_cfg.double_tap_gap})
                begin
                    det_state.gesture_state = GS_IDLE;
                    res.gesture             = EV_TAP;
                end
            end
            GS_SECOND:
            begin
                elapsed = smp.time_ms - det_state.press_start;
                if (!level)
                begin
                    det_state.gesture_state = GS_IDLE;
                    res.gesture             = EV_DOUBLE;
                end
                else if (elapsed >= {16'h0, det_cfg.hold_time})
                    det_state.gesture_state = GS_HELD;
            end
            default:
            begin
                // idle, and any unused code behaves as idle
                det_state.gesture_state = GS_IDLE;
                if (level)
                begin
                    det_state.gesture_state = GS_PRESSED;
                    det_state.press_start   = smp.time_ms;
                end
            end
        endcase
        // Force idle clears the machine only after this sample's event.
        if (smp.force_idle)
            det_state.gesture_state = GS_IDLE;
        res.touched_level = level;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result checking: compare every result transfer with the oldest
    // prediction, field by field.
    // ------------------------------------------------------------------
    tgd_result_t oldest_result;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected nothing, got gesture %0d level %0d",
                         $time, m_tdata[1:0], m_tdata[2]);
                errors++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                results_checked++;
                if (m_tdata[1:0] !== oldest_result.gesture)
                begin
                    $display("%0t ns: gesture mismatch, expected %0d, got %0d",
                             $time, oldest_result.gesture, m_tdata[1:0]);
                    errors++;
                end
                if (m_tdata[2] !== oldest_result.touched_level)
                begin
                    $display("%0t ns: touched level mismatch, expected %0d, got %0d",
                             $time, oldest_result.touched_level, m_tdata[2]);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result-side backpressure: runs of ready and stall of random length.
    // rx_steady keeps ready high for stretches with no stall.
    // ------------------------------------------------------------------
    bit          rx_steady   = 1'b0;
    bit          rx_ready_now = 1'b1;
    int unsigned rx_run      = 0;

    always @(negedge clk)
    begin
        if (rx_run == 0)
        begin
            rx_run       = $urandom_range(1, 8);
            rx_ready_now = $urandom_range(0, 2) != 0;
        end
        rx_run--;
        m_tready <= rx_steady || rx_ready_now;
    end

    // ------------------------------------------------------------------
    // Sample driver: bursts of random length separated by random gaps.
    // tx_steady drops the gaps.
    // ------------------------------------------------------------------
    bit          tx_steady  = 1'b0;
    int unsigned burst_left = 0;

    // Drive one sample, hold it until the transfer, then queue its result.
    // A typed expectation replaces the predicted one, the predictor still
    // advances so that its state follows the block.
    task automatic send_sample(input tgd_sample_t smp, input bit has_typed,
                               input tgd_result_t typed);
        int unsigned gap;
        tgd_result_t predicted;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = tx_steady ? 0 : (($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0);
            if (gap != 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, smp.force_idle, smp.time_ms, smp.touch_reading};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = predict_gesture(smp);
        pending_results.push_back(has_typed ? typed : predicted);
        samples_sent++;
        burst_left--;
    endtask

    // Stop sending and wait until every predicted result has arrived.
    task automatic wait_drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register and mirror it; unknown indexes are ignored.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_THRESHOLD:  det_cfg.touch_cutoff   = val;
            REG_DEBOUNCE:   det_cfg.debounce_time  = val;
            REG_HOLD:       det_cfg.hold_time      = val;
            REG_DOUBLE_GAP: det_cfg.double_tap_gap = val;
            default:        ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_settings(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] deb,
                                 input logic [CFG_W-1:0] hold, input logic [CFG_W-1:0] gap);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_HOLD, hold);
        write_reg(REG_DOUBLE_GAP, gap);
        settings_count++;
    endtask

    // ------------------------------------------------------------------
    // Random gesture generation
    // ------------------------------------------------------------------
    logic [TIME_W-1:0] now_ms = '0;

    // Pick a reading on the touched or untouched side of the threshold,
    // now and then right at the boundary.
    function automatic logic [READING_W-1:0] pick_reading(input bit touched);
        logic [CFG_W-1:0] thr;
        thr = det_cfg.touch_cutoff;
        if (touched && thr != 0)
            return ($urandom_range(0, 7) == 0) ? READING_W'(thr - 16'd1)
                                               : READING_W'($urandom_range(0, thr - 1));
        else if (touched)
            return READING_W'($urandom);
        else
            return ($urandom_range(0, 7) == 0) ? thr
                                               : READING_W'($urandom_range(thr, 65535));
    endfunction

    task automatic emit(input logic [READING_W-1:0] reading);
        tgd_sample_t smp;
        smp.touch_reading = reading;
        smp.time_ms       = now_ms;
        smp.force_idle    = $urandom_range(0, 24) == 0;
        send_sample(smp, 1'b0, '0);
    endtask

    // Hold one intended level for dur ms, spread over a few samples.
    task automatic touch_segment(input bit touched, input int unsigned dur);
        int unsigned k;
        int unsigned part;
        k    = $urandom_range(1, 4);
        part = dur / k;
        for (int unsigned i = 0; i < k; i++)
        begin
            now_ms += (i == k - 1) ? dur - part * (k - 1) : part;
            emit(pick_reading(touched));
        end
    endtask

    // One tap, double tap, hold, contact bounce or noise burst with
    // durations drawn around the current register values.
    task automatic play_gesture();
        int unsigned deb;
        int unsigned hold;
        int unsigned gap;
        int unsigned kind;
        int unsigned reps;
        deb  = 32'(det_cfg.debounce_time);
        hold = 32'(det_cfg.hold_time);
        gap  = 32'(det_cfg.double_tap_gap);
        kind = $urandom_range(0, 19);
        if (kind < 3)
        begin
            // noise: any reading, any time step, wraps included
            case ($urandom_range(0, 2))
                0:       ;
                1:       now_ms += $urandom;
                default: now_ms += $urandom_range(0, 3 * (deb + hold + gap) + 3);
            endcase
            emit(READING_W'($urandom));
        end
        else if (kind < 6)
        begin
            // bounce: level flips faster than the debounce window
            reps = $urandom_range(2, 5);
            repeat (reps) touch_segment($urandom_range(0, 1) != 0, $urandom_range(0, deb));
        end
        else if (kind < 11)
        begin
            touch_segment(1'b1, deb + $urandom_range(0, hold / 2 + 1));
            touch_segment(1'b0, deb + gap + $urandom_range(0, gap + 2));
        end
        else if (kind < 15)
        begin
            touch_segment(1'b1, deb + $urandom_range(0, hold / 2 + 1));
            touch_segment(1'b0, deb + $urandom_range(0, gap / 2 + 1));
            touch_segment(1'b1, deb + $urandom_range(0, hold / 2 + 1));
            touch_segment(1'b0, deb + gap + $urandom_range(0, gap + 2));
        end
        else
        begin
            touch_segment(1'b1, deb + hold + $urandom_range(0, hold + 2));
            touch_segment(1'b0, deb + $urandom_range(0, gap + 2));
        end
    endtask

    // Play gestures until about n_items samples went out; halfway, pause
    // until every result has come back.
    task automatic run_random(input int unsigned n_items);
        int unsigned first;
        bit          drained;
        first   = samples_sent;
        drained = 1'b0;
        while (samples_sent - first < n_items)
        begin
            play_gesture();
            if (!drained && samples_sent - first >= n_items / 2)
            begin
                wait_drain();
                drained = 1'b1;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Directed table, walked under reset settings (threshold 95,
    // debounce 20, hold 1000, gap 400). Rows with typed set carry an
    // expected result read straight off the sequence.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [READING_W-1:0] reading;
        logic [TIME_W-1:0]    stamp;
        logic                 force_idle;
        logic                 typed;
        logic [EVENT_W-1:0]   gesture;
        logic                 level;
    } dir_row_t;

    localparam int unsigned DIR_ROWS = 25;

    dir_row_t directed_rows [0:DIR_ROWS-1] = '{
        // right after reset: untouched, nothing reported
        '{16'hFFFF, 32'd0,        1'b0, 1'b1, EV_NONE,   1'b0},
        // single tap
        '{16'h0000, 32'd100,      1'b0, 1'b0, EV_NONE,   1'b0},
        '{16'h0000, 32'd120,      1'b0, 1'b0, EV_NONE,   1'b0},
        '{16'hFFFF, 32'd200,      1'b0, 1'b0, EV_NONE,   1'b0},
        '{16'hFFFF, 32'd220,      1'b0, 1'b0, EV_NONE,   1'b0},
        '{16'hFFFF, 32'd700,      1'b0, 1'b1, EV_TAP,    1'b0},
        // double tap
        '{16'h0000, 32'd1000,     1'b0, 1'b0, EV_NONE,   1'b0},
        '{16'h0000, 32'd1020,     1'b0, 1'b0, EV_NONE,   1'b0},
        '{16'hFFFF, 32'd1100,     1'b0, 1'b0, EV_NONE,   1'b0},
        '{16'hFFFF, 32'd1120,     1'b0, 1'b0, EV_NONE,   1'b0},
        '{16'h0000, 32'd1200,     1'b0, 1'b0, EV_NONE,   1'b0},
        '{16'h0000, 32'd1220,     1'b0, 1'b0, EV_NONE,   1'b0},
        '{16'hFFFF, 32'd1300,     1'b0, 1'b0, EV_NONE,   1'b0},
        '{16'hFFFF, 32'd1320,     1'b0, 1'b1, EV_DOUBLE, 1'b0},
        // hold, reported on release
        '{16'h0000, 32'd2000,     1'b0, 1'b0, EV_NONE,   1'b0},
        '{16'h0000, 32'd2020,     1'b0, 1'b0, EV_NONE,   1'b0},
        '{16'h0000, 32'd3100,     1'b0, 1'b0, EV_NONE,   1'b0},
        '{16'hFFFF, 32'd3200,     1'b0, 1'b0, EV_NONE,   1'b0},
        '{16'hFFFF, 32'd3220,     1'b0, 1'b1, EV_HOLD,   1'b0},
        // force idle on the sample that starts a press
        '{16'h0000, 32'd4000,     1'b0, 1'b0, EV_NONE,   1'b0},
        '{16'h0000, 32'd4020,     1'b1, 1'b0, EV_NONE,   1'b0},
        '{16'h0000, 32'd4030,     1'b0, 1'b0, EV_NONE,   1'b0},
        // reading at the threshold, timestamp wrap across zero
        '{16'd95,   32'hFFFFFFF0, 1'b0, 1'b0, EV_NONE,   1'b0},
        '{16'd94,   32'hFFFFFFFF, 1'b1, 1'b0, EV_NONE,   1'b0},
        '{16'd94,   32'h00000013, 1'b0, 1'b0, EV_NONE,   1'b0}
    };

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        tgd_sample_t smp;
        tgd_result_t typed;
        @(posedge rst_n);
        settings_count = 1;

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            smp.touch_reading   = directed_rows[i].reading;
            smp.time_ms         = directed_rows[i].stamp;
            smp.force_idle      = directed_rows[i].force_idle;
            typed.gesture       = directed_rows[i].gesture;
            typed.touched_level = directed_rows[i].level;
            send_sample(smp, directed_rows[i].typed, typed);
        end
        now_ms = directed_rows[DIR_ROWS-1].stamp;
        wait_drain();

        // short windows so that every gesture plays out in a few samples
        load_settings(CFG_W'($urandom_range(1, 65535)), CFG_W'($urandom_range(0, 8)),
                      CFG_W'($urandom_range(10, 80)), CFG_W'($urandom_range(5, 50)));
        run_random(110);
        wait_drain();

        // every time zero, everything below threshold touched; drop a
        // write to an unknown index
        load_settings(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
        write_reg(8'hFF, 16'hFFFF);
        run_random(70);
        wait_drain();

        // every time at its maximum, nothing counts as touched
        load_settings(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        write_reg(8'h04, 16'h0000);
        run_random(40);
        wait_drain();

        // longer windows, first half with no idling on either side
        load_settings(CFG_W'($urandom_range(1, 65535)), CFG_W'($urandom_range(0, 40)),
                      CFG_W'($urandom_range(0, 300)), CFG_W'($urandom_range(0, 200)));
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        run_random(70);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        run_random(70);
        wait_drain();

        // back to the reset values, written explicitly
        load_settings(THRESHOLD_RST, DEBOUNCE_RST, HOLD_RST, DOUBLE_GAP_RST);
        run_random(140);
        wait_drain();

        $display("Covered %0d samples and %0d checked results over %0d register settings,",
                 samples_sent, results_checked, settings_count);
        $display("with tap, double tap, hold, bounce, force idle, timestamp wrap and limits.");
        if (errors == 0)
            $display("touch_gesture_detector_tb passed");
        else
            $display("touch_gesture_detector_tb failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("Timeout with %0d results still pending", pending_results.size());
        $display("touch_gesture_detector_tb failed");
        $finish;
    end

endmodule

>>> filelist.f
sv/tgd_pkg.sv
sv/tgd_cfg_regs.sv
sv/tgd_step.sv
sv/touch_gesture_detector.sv
sv/tgd_checker.sv
tb/sv/touch_gesture_detector_tb.sv
